>>> hw/rtl/eatl_pkg.sv
// Shared types, constants and tables of the equal-angle tree layout block.
package eatl_pkg;
	localparam int NODE_BITS   = 10;
	localparam int ANGLE_BITS  = 16;
	localparam int CUR_BITS    = ANGLE_BITS + 1;
	localparam int LEAF_BITS   = 11;
	localparam int LEN_BITS    = 16;
	localparam int COORD_BITS  = 32;
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_BITS   = 4;
	localparam int DIV_STEPS   = LEAF_BITS + ANGLE_BITS;
	localparam int DIV_CNT_BITS = 5;
	localparam logic [33:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic CMD_ROOT  = 1'b0;
	localparam logic CMD_CHILD = 1'b1;

	typedef struct packed {
		logic                  cmd;
		logic [NODE_BITS-1:0]  node_id;
		logic [NODE_BITS-1:0]  parent_id;
		logic [LEAF_BITS-1:0]  leaf_cnt;
		logic [LEN_BITS-1:0]   branch_length;
	} in_item_t;

	typedef struct packed {
		logic [NODE_BITS-1:0]         out_node_id;
		logic signed [COORD_BITS-1:0] x_coord;
		logic signed [COORD_BITS-1:0] y_coord;
	} out_item_t;

	// Handshake between sequencer and shared rotation unit.
	typedef struct packed {
		logic                  start;
		logic [ANGLE_BITS-1:0] angle;
	} cordic_req_t;

	typedef struct packed {
		logic               done;
		logic signed [15:0] cos_q15;
		logic signed [15:0] sin_q15;
	} cordic_rsp_t;

	function automatic logic [31:0] atan_turn(input logic [STEP_BITS-1:0] i);
		logic [31:0] r;
		case (i)
			4'd0:  r = 32'h20000000;
			4'd1:  r = 32'h12E4051E;
			4'd2:  r = 32'h09FB385B;
			4'd3:  r = 32'h051111D4;
			4'd4:  r = 32'h028B0D43;
			4'd5:  r = 32'h0145D7E1;
			4'd6:  r = 32'h00A2F61E;
			4'd7:  r = 32'h00517C55;
			4'd8:  r = 32'h0028BE53;
			4'd9:  r = 32'h00145F2F;
			4'd10: r = 32'h000A2F98;
			4'd11: r = 32'h000517CC;
			4'd12: r = 32'h00028BE6;
			4'd13: r = 32'h000145F3;
			4'd14: r = 32'h0000A2FA;
			default: r = 32'h0000517D;
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] to_q15(input logic signed [34:0] v);
		logic signed [34:0] r;
		r = (v + 35'sd16384) >>> 15;
		if (r > 35'sd32767) return 16'sh7FFF;
		if (r < -35'sd32768) return 16'sh8000;
		return r[15:0];
	endfunction
endpackage

>>> hw/rtl/eatl_if.sv
// Valid/ready stream interfaces for the input and result channels.
interface eatl_in_if (input logic clk);
	logic                 valid;
	logic                 ready;
	eatl_pkg::in_item_t   data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface eatl_out_if (input logic clk);
	logic                 valid;
	logic                 ready;
	eatl_pkg::out_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/eatl_cordic.sv
// Iterative CORDIC rotation unit giving cos and sin in Q1.15.
module eatl_cordic (
	input  logic                  clk,
	input  logic                  arst_n,
	input  eatl_pkg::cordic_req_t req,
	output eatl_pkg::cordic_rsp_t rsp
);
	logic                                busy_q;
	logic [eatl_pkg::STEP_BITS-1:0]      step_q;
	logic [1:0]                          quad_q;
	logic signed [33:0]                  x_q, y_q;
	logic signed [32:0]                  z_q;
	logic signed [33:0]                  dx, dy;
	logic signed [32:0]                  at;
	logic signed [34:0]                  cx, sy;
	logic                                done_q;

	assign dx = y_q >>> step_q;
	assign dy = x_q >>> step_q;
	assign at = $signed({1'b0, eatl_pkg::atan_turn(step_q)});

	always_comb begin
		case (quad_q)
			2'd0: begin cx = 35'(x_q);  sy = 35'(y_q);  end
			2'd1: begin cx = -35'(y_q); sy = 35'(x_q);  end
			2'd2: begin cx = -35'(x_q); sy = -35'(y_q); end
			default: begin cx = 35'(y_q); sy = -35'(x_q); end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == eatl_pkg::STEP_BITS'(eatl_pkg::CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quad_q <= req.angle[eatl_pkg::ANGLE_BITS-1 -: 2];
			x_q    <= eatl_pkg::CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= $signed({3'b000, req.angle[eatl_pkg::ANGLE_BITS-3:0],
				(32 - eatl_pkg::ANGLE_BITS)'(0)});
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + at;
			end
		end
	end

	// While done is high the rotation has finished and x/y hold their final values.
	assign rsp.done    = done_q;
	assign rsp.cos_q15 = eatl_pkg::to_q15(cx);
	assign rsp.sin_q15 = eatl_pkg::to_q15(sy);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> $past(busy_q)) else $error("done without work");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.start) else $error("start while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done) else $error("done held");
endmodule

>>> hw/rtl/equal_angle_tree_layout_top.sv
// Top level: sequencer, wedge divider, node stores and coordinate update.
//  channel | dir | handshake        | payload
//  in_ch   | in  | valid/ready      | cmd node_id parent_id leaf_cnt branch_length
//  out_ch  | out | valid/ready      | out_node_id x_coord y_coord
//  cfg     | in  | cfg_we           | cfg_data = total_leaves (11 bit)
// A child node passes in order through a store read, 27 divider steps, a CORDIC start, the
// wait on the shared CORDIC unit, two multiply/add passes, a write, the result state and idle.
// A root node goes from acceptance straight to the write and then the result state.
// Only one transaction is in flight at a time.
// Reset sets total_leaves to 1; node stores are undefined until written.
// in_ch.ready stays low from acceptance until the result transaction is taken;
// while out_ch.ready is low the block waits in the result state.
module equal_angle_tree_layout_top (
	input  logic                              clk,
	input  logic                              arst_n,
	eatl_in_if.sink                           in_ch,
	eatl_out_if.source                        out_ch,
	input  logic                              cfg_we,
	input  logic [eatl_pkg::LEAF_BITS-1:0]    cfg_data
);
	localparam logic [3:0] ST_IDLE = 4'd0, ST_READ = 4'd1, ST_DIV = 4'd2,
		ST_TRIG = 4'd3, ST_WAIT = 4'd4, ST_MULX = 4'd5, ST_MULY = 4'd6,
		ST_WRITE = 4'd7, ST_OUT = 4'd8;
	localparam int CB = eatl_pkg::CUR_BITS;
	localparam int DN = eatl_pkg::DIV_STEPS;
	localparam logic [CB-1:0] CUR_MAX = '1;

	logic [3:0]                           state_q;
	eatl_pkg::in_item_t                   item_q;
	logic [eatl_pkg::LEAF_BITS-1:0]       total_q;
	logic [CB-1:0]                        cur_mem [2**eatl_pkg::NODE_BITS];
	logic [31:0]                          x_mem [2**eatl_pkg::NODE_BITS];
	logic [31:0]                          y_mem [2**eatl_pkg::NODE_BITS];
	logic [CB-1:0]                        low_q;
	logic signed [31:0]                   px_q, py_q;
	logic [DN-1:0]                        quo_q;
	logic [eatl_pkg::LEAF_BITS:0]         rem_q;
	logic [DN-1:0]                        dvd_q;
	logic [eatl_pkg::DIV_CNT_BITS-1:0]    cnt_q;
	logic [eatl_pkg::LEAF_BITS-1:0]       divisor;
	logic [eatl_pkg::LEAF_BITS:0]         rem_sh;
	logic [CB-1:0]                        wedge;
	logic [CB:0]                          next_sum;
	eatl_pkg::cordic_req_t                creq;
	eatl_pkg::cordic_rsp_t                crsp;
	logic signed [15:0]                   cos_q, sin_q;
	logic signed [31:0]                   prod;
	logic signed [33:0]                   sum;
	logic signed [31:0]                   sat;
	logic signed [31:0]                   xr_q, yr_q;
	logic                                 ovalid_q;

	eatl_cordic u_cordic (.clk(clk), .arst_n(arst_n), .req(creq), .rsp(crsp));

	assign divisor = (total_q == '0) ? eatl_pkg::LEAF_BITS'(1) : total_q;
	assign rem_sh  = {rem_q[eatl_pkg::LEAF_BITS-1:0], dvd_q[DN-1]};
	assign wedge   = (|quo_q[DN-1:CB]) ? CUR_MAX : quo_q[CB-1:0];
	assign next_sum = {1'b0, low_q} + {1'b0, wedge};
	assign creq.start = (state_q == ST_TRIG);
	assign creq.angle = low_q[eatl_pkg::ANGLE_BITS-1:0] + wedge[CB-1:1];

	// One shared signed multiply and saturating add serves x then y.
	assign prod = $signed({16'd0, item_q.branch_length}) *
		32'(state_q == ST_MULX ? cos_q : sin_q);
	assign sum  = 34'(state_q == ST_MULX ? px_q : py_q) + 34'(prod >>> 7);
	assign sat  = (sum > 34'sh07FFFFFFF) ? 32'sh7FFFFFFF :
		(sum < -34'sh080000000) ? 32'sh80000000 : sum[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			total_q  <= eatl_pkg::LEAF_BITS'(1);
			ovalid_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (cfg_we) total_q <= cfg_data;
			unique case (state_q)
				ST_IDLE: if (in_ch.valid) begin
					state_q <= (in_ch.data.cmd == eatl_pkg::CMD_ROOT) ? ST_WRITE : ST_READ;
				end
				ST_READ: begin
					state_q <= ST_DIV;
					cnt_q   <= '0;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == eatl_pkg::DIV_CNT_BITS'(DN - 1)) state_q <= ST_TRIG;
				end
				ST_TRIG: state_q <= ST_WAIT;
				ST_WAIT: if (crsp.done) state_q <= ST_MULX;
				ST_MULX: state_q <= ST_MULY;
				ST_MULY: state_q <= ST_WRITE;
				ST_WRITE: begin
					state_q  <= ST_OUT;
					ovalid_q <= 1'b1;
				end
				ST_OUT: if (out_ch.ready) begin
					ovalid_q <= 1'b0;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid) begin
			item_q <= in_ch.data;
			xr_q   <= '0;
			yr_q   <= '0;
		end
		if (state_q == ST_READ) begin
			low_q <= cur_mem[item_q.parent_id];
			px_q  <= x_mem[item_q.parent_id];
			py_q  <= y_mem[item_q.parent_id];
			dvd_q <= {item_q.leaf_cnt, eatl_pkg::ANGLE_BITS'(0)};
			rem_q <= '0;
			quo_q <= '0;
		end
		if (state_q == ST_DIV) begin
			dvd_q <= dvd_q << 1;
			if (rem_sh >= {1'b0, divisor}) begin
				rem_q <= rem_sh - {1'b0, divisor};
				quo_q <= {quo_q[DN-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[DN-2:0], 1'b0};
			end
		end
		if (crsp.done) begin
			cos_q <= crsp.cos_q15;
			sin_q <= crsp.sin_q15;
		end
		if (state_q == ST_MULX) xr_q <= sat;
		if (state_q == ST_MULY) yr_q <= sat;
		if (state_q == ST_WRITE) begin
			if (item_q.cmd == eatl_pkg::CMD_ROOT) begin
				cur_mem[item_q.node_id] <= '0;
				x_mem[item_q.node_id]   <= '0;
				y_mem[item_q.node_id]   <= '0;
			end else begin
				// A node that names itself as parent keeps the advanced cursor.
				cur_mem[item_q.parent_id] <= next_sum[CB] ? CUR_MAX : next_sum[CB-1:0];
				if (item_q.node_id != item_q.parent_id)
					cur_mem[item_q.node_id] <= low_q;
				x_mem[item_q.node_id]     <= xr_q;
				y_mem[item_q.node_id]     <= yr_q;
			end
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = ovalid_q;
	assign out_ch.data.out_node_id = item_q.node_id;
	assign out_ch.data.x_coord = xr_q;
	assign out_ch.data.y_coord = yr_q;

	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("ready while result pending");
	a_out_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(state_q) == ST_WRITE) else $error("bad result");
	a_trig_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TRIG |-> $past(state_q) == ST_DIV) else $error("skipped divide");
endmodule
